/* rtl/xmtc_pkg.sv */
// ============================================================================
// xmtc_pkg
// Shared types, constants and helper functions for the xorshift memory test
// checker: request codes, queue entry layout and the register clamping rules.
// ============================================================================
package xmtc_pkg;

  // Width of the internal word counter and segment offset.
  localparam int WORD_INDEX_BITS = 30;

  // Fixed field widths of the ports.
  localparam int ADDR_W  = 30;
  localparam int DATA_W  = 32;
  localparam int REQ_W   = 2;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 1;

  // Width used to compare counters against the clamped register values.
  localparam int CMP_W = (WORD_INDEX_BITS + 1 > DATA_W) ? WORD_INDEX_BITS + 1 : DATA_W;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Generator seed.
  localparam logic [DATA_W-1:0] SEED_X = 32'd123456789;
  localparam logic [DATA_W-1:0] SEED_Y = 32'd362436069;
  localparam logic [DATA_W-1:0] SEED_Z = 32'd521288629;
  localparam logic [DATA_W-1:0] SEED_W = 32'd88675123;

  // Register reset values.
  localparam logic [CFG_W-1:0] TOTAL_RESET   = 31'd1024;
  localparam logic [CFG_W-1:0] SEGMENT_RESET = 31'd1024;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_VERIFY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_VERIFY,
    KIND_START,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  pattern;
    logic [DATA_W-1:0]  rdata;
    logic               done;
  } item_t;

  // Total words: zero counts as one, and the value is capped at the counter range.
  function automatic logic [CMP_W-1:0] eff_total_f(input logic [CFG_W-1:0] raw);
    logic [CMP_W-1:0] cap;
    logic [CMP_W-1:0] v;
    cap = CMP_W'(1) << WORD_INDEX_BITS;
    v   = (raw == '0) ? CMP_W'(1) : CMP_W'(raw);
    if (v > cap) begin
      v = cap;
    end
    return v;
  endfunction

  // Segment words: rounded up to a multiple of 16, at least 16.
  function automatic logic [CMP_W-1:0] eff_segment_f(input logic [CFG_W-1:0] raw);
    logic [CMP_W-1:0] v;
    v = (CMP_W'(raw) + CMP_W'(15)) & ~CMP_W'(15);
    if (v < CMP_W'(16)) begin
      v = CMP_W'(16);
    end
    return v;
  endfunction

endpackage

/* rtl/xmtc_front.sv */
// ============================================================================
// xmtc_front
// Accepts requests, holds the configuration, the generator and the counters,
// and turns each request into a classified queue entry.
// ============================================================================
module xmtc_front import xmtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [DATA_W-1:0]     read_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output item_t                 entry
);

  logic [CMP_W-1:0]           eff_total_r, eff_total_nxt;
  logic [CMP_W-1:0]           eff_seg_r, eff_seg_nxt;
  logic [DATA_W-1:0]          gx_r, gy_r, gz_r, gw_r;
  logic [DATA_W-1:0]          gx_nxt, gy_nxt, gz_nxt, gw_nxt;
  logic [WORD_INDEX_BITS-1:0] widx_r, widx_nxt;
  logic [WORD_INDEX_BITS-1:0] soff_r, soff_nxt;

  logic [DATA_W-1:0] bx, by, bz, bw, t, pat;
  logic [CMP_W-1:0]  widx_inc, soff_inc;
  logic              last_word, last_seg;

  // Configuration is stored already clamped.
  always_comb begin
    eff_total_nxt = eff_total_r;
    eff_seg_nxt   = eff_seg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TOTAL:   eff_total_nxt = eff_total_f(cfg_wdata);
        CFG_SEGMENT: eff_seg_nxt   = eff_segment_f(cfg_wdata);
        default:     eff_total_nxt = eff_total_r;
      endcase
    end
  end

  // One xorshift128 step, starting from the seed at a segment start.
  always_comb begin
    if (soff_r == '0) begin
      bx = SEED_X; by = SEED_Y; bz = SEED_Z; bw = SEED_W;
    end else begin
      bx = gx_r; by = gy_r; bz = gz_r; bw = gw_r;
    end
    t   = bx ^ (bx << 11);
    pat = bw ^ (bw >> 19) ^ t ^ (t >> 8);
  end

  assign widx_inc  = CMP_W'(widx_r) + CMP_W'(1);
  assign soff_inc  = CMP_W'(soff_r) + CMP_W'(1);
  assign last_word = (widx_inc >= eff_total_r);
  assign last_seg  = (soff_inc >= eff_seg_r);

  always_comb begin
    gx_nxt   = gx_r;
    gy_nxt   = gy_r;
    gz_nxt   = gz_r;
    gw_nxt   = gw_r;
    widx_nxt = widx_r;
    soff_nxt = soff_r;
    entry.kind    = KIND_NONE;
    entry.addr    = ADDR_W'(CMP_W'(widx_r));
    entry.pattern = pat;
    entry.rdata   = read_data;
    entry.done    = last_word;
    case (req_type)
      REQ_WRITE, REQ_VERIFY: begin
        entry.kind = (req_type == REQ_VERIFY) ? KIND_VERIFY : KIND_WRITE;
        if (fire) begin
          gx_nxt = by;
          gy_nxt = bz;
          gz_nxt = bw;
          gw_nxt = pat;
          if (last_word) begin
            widx_nxt = '0;
            soff_nxt = '0;
          end else begin
            widx_nxt = WORD_INDEX_BITS'(widx_inc);
            soff_nxt = last_seg ? '0 : WORD_INDEX_BITS'(soff_inc);
          end
        end
      end
      REQ_START: begin
        entry.kind = KIND_START;
        if (fire) begin
          gx_nxt   = SEED_X;
          gy_nxt   = SEED_Y;
          gz_nxt   = SEED_Z;
          gw_nxt   = SEED_W;
          widx_nxt = '0;
          soff_nxt = '0;
        end
      end
      default: entry.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_total_r <= eff_total_f(TOTAL_RESET);
      eff_seg_r   <= eff_segment_f(SEGMENT_RESET);
      gx_r        <= SEED_X;
      gy_r        <= SEED_Y;
      gz_r        <= SEED_Z;
      gw_r        <= SEED_W;
      widx_r      <= '0;
      soff_r      <= '0;
    end else begin
      eff_total_r <= eff_total_nxt;
      eff_seg_r   <= eff_seg_nxt;
      gx_r        <= gx_nxt;
      gy_r        <= gy_nxt;
      gz_r        <= gz_nxt;
      gw_r        <= gw_nxt;
      widx_r      <= widx_nxt;
      soff_r      <= soff_nxt;
    end
  end

endmodule

/* rtl/xmtc_queue.sv */
// ============================================================================
// xmtc_queue
// Small first-in first-out queue of classified requests between the front
// and the back.
// ============================================================================
module xmtc_queue import xmtc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue popped while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

/* rtl/xmtc_back.sv */
// ============================================================================
// xmtc_back
// Compares read data with the pattern, keeps the sticky error flag and holds
// the result in the output register.
// ============================================================================
module xmtc_back import xmtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  item_t             head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_word_address,
  output logic [DATA_W-1:0] out_pattern_word,
  output logic              out_mismatch,
  output logic [DATA_W-1:0] out_difference_bits,
  output logic              out_error_seen,
  output logic              out_pass_done
);

  logic              valid_r, valid_nxt;
  logic              err_r, err_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] pat_r, pat_nxt;
  logic              mis_r, mis_nxt;
  logic [DATA_W-1:0] diff_r, diff_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] cmp;

  assign pop = head_valid && (!valid_r || out_ready);
  assign cmp = head.pattern ^ head.rdata;

  always_comb begin
    valid_nxt = valid_r;
    err_nxt   = err_r;
    addr_nxt  = addr_r;
    pat_nxt   = pat_r;
    mis_nxt   = mis_r;
    diff_nxt  = diff_r;
    done_nxt  = done_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (pop) begin
      valid_nxt = 1'b1;
      addr_nxt  = head.addr;
      pat_nxt   = head.pattern;
      mis_nxt   = 1'b0;
      diff_nxt  = '0;
      done_nxt  = head.done;
      case (head.kind)
        KIND_WRITE: begin
        end
        KIND_VERIFY: begin
          diff_nxt = cmp;
          mis_nxt  = (cmp != '0);
          err_nxt  = err_r | (cmp != '0);
        end
        KIND_START: begin
          err_nxt  = 1'b0;
          addr_nxt = '0;
          pat_nxt  = '0;
          done_nxt = 1'b0;
        end
        default: begin
          pat_nxt  = '0;
          done_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    pat_r  <= pat_nxt;
    mis_r  <= mis_nxt;
    diff_r <= diff_nxt;
    done_r <= done_nxt;
  end

  assign out_valid           = valid_r;
  assign out_word_address    = addr_r;
  assign out_pattern_word    = pat_r;
  assign out_mismatch        = mis_r;
  assign out_difference_bits = diff_r;
  assign out_error_seen      = err_r;
  assign out_pass_done       = done_r;

endmodule

/* rtl/xorshift_memory_test_checker_unit.sv */
// A request is written into the queue, and the back then moves it into its output register,
// from which the result is taken.
// Throughput: one request per cycle while the queue has room; the front step is combinational.
// The four-entry queue lets the front keep accepting while a result waits to be taken.
// Reset (rst_n low, synchronous) reseeds the generator, clears the counters, the error
// flag and the queue, and loads 1024 into both configuration registers.
// ============================================================================
// xorshift_memory_test_checker_unit
// Memory test pattern generator and checker built on an xorshift128 sequence.
// ============================================================================
module xorshift_memory_test_checker_unit import xmtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [DATA_W-1:0]    in_read_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_word_address,
  output logic [DATA_W-1:0]    out_pattern_word,
  output logic                 out_mismatch,
  output logic [DATA_W-1:0]    out_difference_bits,
  output logic                 out_error_seen,
  output logic                 out_pass_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  item_t front_entry;
  item_t q_head;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  in_fire;

  // A request is taken whenever the queue has room; the front updates the
  // generator and counters in that same cycle, so requests flow back to back.
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;
  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  // Front: register file, generator and word counters. Each request becomes
  // one classified entry carrying the address, the pattern and the read data.
  xmtc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .req_type  (in_req_type),
    .read_data (in_read_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .entry     (front_entry)
  );

  // Queue between the two halves, so a stalled output does not stop the front until the queue fills.
  xmtc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_item (front_entry),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: compare, sticky error flag and output register.
  xmtc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (q_head),
    .head_valid          (!q_empty),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_word_address    (out_word_address),
    .out_pattern_word    (out_pattern_word),
    .out_mismatch        (out_mismatch),
    .out_difference_bits (out_difference_bits),
    .out_error_seen      (out_error_seen),
    .out_pass_done       (out_pass_done)
  );

  // A reported mismatch always comes with nonzero differing bits.
  a_mismatch_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mismatch) |-> (out_difference_bits != '0))
    else $error("mismatch without differing bits");

  // A mismatch always sets the sticky flag in the same result.
  a_mismatch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mismatch) |-> out_error_seen)
    else $error("mismatch did not set the error flag");

  // The input side stalls only when the queue is full.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_full)
    else $error("input stalled with room in the queue");

endmodule
